>>> rtl/base64_stream_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shared property macros for the decoder's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define B64SD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64sd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define B64SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64sd assertion failed");

`endif

>>> rtl/b64sd_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Payload types, the classified character type and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64sd_pkg;

   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic [5:0] sextet;
      logic       in_alphabet;
      logic       line_break;
      logic       end_of_text;
   } class_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   function automatic class_type classify(input req_payload_type beat);
      class_type  result;
      logic [7:0] ch;
      ch = beat.char_code;
      result.sextet      = 6'd0;
      result.in_alphabet = 1'b1;
      result.line_break  = (ch == CHAR_CR) || (ch == CHAR_LF);
      result.end_of_text = beat.end_of_text;
      if (ch >= 8'd65 && ch <= 8'd90) begin
         result.sextet = 6'(ch - 8'd65);
      end else if (ch >= 8'd97 && ch <= 8'd122) begin
         result.sextet = 6'(ch - 8'd71);
      end else if (ch >= 8'd48 && ch <= 8'd57) begin
         result.sextet = 6'(ch + 8'd4);
      end else if (ch == 8'd43) begin
         result.sextet = 6'd62;
      end else if (ch == 8'd47) begin
         result.sextet = 6'd63;
      end else begin
         result.in_alphabet = 1'b0;
      end
      return result;
   endfunction

endpackage

>>> rtl/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder top level
// Decodes a base64 character stream into bytes, one character per beat.
//
//   Channel | Direction | Handshake          | Beat contents
//   req     | in        | req_valid/req_stall | char_code, end_of_text
//   rsp     | out       | rsp_valid/rsp_stall | data_byte, final_byte
//
// One character beat is accepted every cycle while the result side keeps up.
// A result passes through the front register, a queue entry and the output register before it is valid.
// Reset is synchronous and clears the queue, the group state and both valids;
// while it is high req_stall is high and rsp_valid is low.
// A stalled result holds in the output register; the two-entry queue and the
// front register absorb beats before req_stall rises.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  b64sd_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output b64sd_pkg::rsp_payload_type rsp_payload
);
   import b64sd_pkg::*;

   logic             push;
   logic             pop;
   class_type        push_item;
   class_type        head_item;
   queue_status_type status;

   b64sd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (status.full),
      .push        (push),
      .push_item   (push_item)
   );

   b64sd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .status    (status),
      .head_item (head_item)
   );

   b64sd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .status      (status),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/b64sd_front.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder front end
// Accepts character beats and registers their alphabet classification.
// ----------------------------------------------------------------------------
module b64sd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  b64sd_pkg::req_payload_type req_payload,
   input  logic                      queue_full,
   output logic                      push,
   output b64sd_pkg::class_type      push_item
);
   import b64sd_pkg::*;

   logic      valid_ff, valid_in;
   class_type item_ff;
   logic      take;

   assign push      = valid_ff && !queue_full;
   assign req_stall = reset || (valid_ff && queue_full);
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && queue_full);
   assign push_item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= classify(req_payload);
      end
   end

endmodule

>>> rtl/b64sd_queue.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder queue
// Two-entry queue of classified characters between front and back end.
// ----------------------------------------------------------------------------
module b64sd_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  b64sd_pkg::class_type           push_item,
   input  logic                           pop,
   output b64sd_pkg::queue_status_type    status,
   output b64sd_pkg::class_type           head_item
);
   import b64sd_pkg::*;

   class_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign head_item    = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/b64sd_back.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder back end
// Tracks group position, assembles bytes and holds the result register.
// ----------------------------------------------------------------------------
module b64sd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  b64sd_pkg::queue_status_type    status,
   input  b64sd_pkg::class_type           head_item,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output b64sd_pkg::rsp_payload_type     rsp_payload
);
   import b64sd_pkg::*;
   `include "base64_stream_decoder_top_assert.svh"

   logic [1:0]      pos_ff, pos_in;
   logic [5:0]      prev_ff, prev_in;
   logic            stopped_ff, stopped_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   logic            emit;
   logic            fin;
   logic [7:0]      byte_value;
   logic [5:0]      v;
   logic            ok;

   assign pop = status.valid && (!rsp_valid_ff || !rsp_stall);
   assign v   = head_item.sextet;
   assign ok  = head_item.in_alphabet;

   always_comb begin
      pos_in     = pos_ff;
      prev_in    = prev_ff;
      stopped_in = stopped_ff;
      emit       = 1'b0;
      fin        = 1'b0;
      byte_value = 8'd0;
      if (pop) begin
         if (!stopped_ff) begin
            unique case (pos_ff)
               POS_FIRST: begin
                  if (!head_item.line_break) begin
                     prev_in = v;
                     pos_in  = POS_SECOND;
                  end
               end
               POS_SECOND: begin
                  byte_value = {prev_ff, v[5:4]};
                  emit       = 1'b1;
                  if (!ok) begin
                     fin        = 1'b1;
                     stopped_in = 1'b1;
                  end else begin
                     prev_in = v;
                     pos_in  = POS_THIRD;
                  end
               end
               POS_THIRD: begin
                  if (!ok) begin
                     stopped_in = 1'b1;
                  end else begin
                     byte_value = {prev_ff[3:0], v[5:2]};
                     emit       = 1'b1;
                     prev_in    = v;
                     pos_in     = POS_FOURTH;
                  end
               end
               POS_FOURTH: begin
                  if (!ok) begin
                     stopped_in = 1'b1;
                  end else begin
                     byte_value = {prev_ff[1:0], v};
                     emit       = 1'b1;
                     prev_in    = 6'd0;
                     pos_in     = POS_FIRST;
                  end
               end
               default: begin
                  pos_in = POS_FIRST;
               end
            endcase
         end
         if (head_item.end_of_text) begin
            fin        = emit;
            pos_in     = POS_FIRST;
            prev_in    = 6'd0;
            stopped_in = 1'b0;
         end
      end
   end

   assign rsp_valid_in = pop ? emit : (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff && !reset;
   assign rsp_payload  = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_FIRST;
         prev_ff      <= 6'd0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         prev_ff      <= prev_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_payload_ff.data_byte  <= byte_value;
         rsp_payload_ff.final_byte <= fin;
      end
   end

   `B64SD_ASSERT_SAME(a_no_byte_when_stopped, clock, reset,
                      pop && stopped_ff, !emit)
   `B64SD_ASSERT_SAME(a_no_byte_at_group_start, clock, reset,
                      pop && (pos_ff == POS_FIRST), !emit)
   `B64SD_ASSERT_NEXT(a_eot_restarts, clock, reset,
                      pop && head_item.end_of_text, (pos_ff == POS_FIRST) && !stopped_ff)
   `B64SD_ASSERT_NEXT(a_stalled_result_held, clock, reset,
                      rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_payload_ff))

endmodule

>>> tb/base64_stream_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream decoder checker
// Watches both channels of the decoder. It keeps its own group position,
// previous sextet and halt flag, predicts the bytes that the accepted
// character beats produce, and compares each accepted result beat with the oldest
// pending byte.
// ----------------------------------------------------------------------------
module base64_stream_decoder_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  b64sd_pkg::req_payload_type req_payload,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  b64sd_pkg::rsp_payload_type rsp_payload,
   output int                         failures,
   output int                         outstanding,
   output int                         bytes_checked
);
   import b64sd_pkg::*;

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic [1:0]      group_pos   = POS_FIRST;
   logic [5:0]      prev_sextet = 6'd0;
   logic            halted      = 1'b0;
   rsp_payload_type expected_bytes[$];

   function automatic logic [6:0] sextet_of(input logic [7:0] ch);
      logic [6:0] found;
      int         i;
      found = 7'd0;
      for (i = 0; i < 64; i++) begin
         if (ALPHABET[8*(63-i) +: 8] == ch) begin
            found = {1'b1, 6'(i)};
         end
      end
      return found;
   endfunction

   function automatic void decode_char(input req_payload_type beat);
      logic [6:0] lookup;
      logic       ok;
      logic [5:0] v;
      logic       emit;
      logic       fin;
      logic [7:0] data;
      lookup = sextet_of(beat.char_code);
      ok     = lookup[6];
      v      = lookup[5:0];
      emit   = 1'b0;
      fin    = 1'b0;
      data   = 8'd0;
      if (!halted) begin
         case (group_pos)
            POS_FIRST: begin
               if (beat.char_code != CHAR_CR && beat.char_code != CHAR_LF) begin
                  prev_sextet = v;
                  group_pos   = POS_SECOND;
               end
            end
            POS_SECOND: begin
               data = {prev_sextet, v[5:4]};
               emit = 1'b1;
               if (!ok) begin
                  fin    = 1'b1;
                  halted = 1'b1;
               end else begin
                  prev_sextet = v;
                  group_pos   = POS_THIRD;
               end
            end
            POS_THIRD: begin
               if (!ok) begin
                  halted = 1'b1;
               end else begin
                  data        = {prev_sextet[3:0], v[5:2]};
                  emit        = 1'b1;
                  prev_sextet = v;
                  group_pos   = POS_FOURTH;
               end
            end
            default: begin
               if (!ok) begin
                  halted = 1'b1;
               end else begin
                  data        = {prev_sextet[1:0], v};
                  emit        = 1'b1;
                  prev_sextet = 6'd0;
                  group_pos   = POS_FIRST;
               end
            end
         endcase
      end
      if (beat.end_of_text) begin
         if (emit) begin
            fin = 1'b1;
         end
         group_pos   = POS_FIRST;
         prev_sextet = 6'd0;
         halted      = 1'b0;
      end
      if (emit) begin
         expected_bytes.push_back('{data_byte: data, final_byte: fin});
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      int              errs;
      int              seen;
      errs = 0;
      seen = 0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = 1;
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected result beat, byte %h final %b", $time,
                        rsp_payload.data_byte, rsp_payload.final_byte);
               errs = 1;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_payload.data_byte != want.data_byte ||
                   rsp_payload.final_byte != want.final_byte) begin
                  $display("%0t: result mismatch, expected byte %h final %b, got byte %h final %b",
                           $time, want.data_byte, want.final_byte,
                           rsp_payload.data_byte, rsp_payload.final_byte);
                  errs = 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_char(req_payload);
         end
      end
      failures      <= failures + errs;
      bytes_checked <= bytes_checked + seen;
      outstanding   <= expected_bytes.size();
   end

endmodule

>>> tb/base64_stream_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Drives a short directed set of character beats and then random base64
// messages with line breaks, noise and end-of-text marks, under changing
// mixes of sender gaps and result stalls. A separate checker predicts and
// compares the decoded bytes; this module gives the verdict.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top_tb;
   import b64sd_pkg::*;

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int RANDOM_BEATS = 550;
   localparam int CYCLE_LIMIT  = 200000;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   int failures;
   int outstanding;
   int bytes_checked;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int beats_sent    = 0;
   int directed_beats;
   int cycle_count   = 0;

   base64_stream_decoder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   base64_stream_decoder_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .failures      (failures),
      .outstanding   (outstanding),
      .bytes_checked (bytes_checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] alphabet_char(input int index);
      return ALPHABET[8*(63-index) +: 8];
   endfunction

   task automatic send_beat(input logic [7:0] ch, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{char_code: ch, end_of_text: eot};
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic send_message();
      int         len;
      int         i;
      logic [7:0] ch;
      bit         closes;
      len    = $urandom_range(24, 1);
      closes = ($urandom_range(9) != 0);
      for (i = 0; i < len; i++) begin
         if (i != 0 && i % 4 == 0 && $urandom_range(99) < 15) begin
            send_beat($urandom_range(1) ? CHAR_CR : CHAR_LF, 1'b0);
         end
         if ($urandom_range(99) < 4) begin
            ch = 8'($urandom_range(255));
         end else begin
            ch = alphabet_char($urandom_range(63));
         end
         send_beat(ch, closes && (i == len - 1));
      end
   endtask

   task automatic set_mix(input int mix);
      case (mix)
         0: begin
            send_idle_pct  = 0;
            rsp_stall_pct <= 0;
         end
         1: begin
            send_idle_pct  = 88;
            rsp_stall_pct <= 0;
         end
         2: begin
            send_idle_pct  = 0;
            rsp_stall_pct <= 88;
         end
         default: begin
            send_idle_pct  = 11;
            rsp_stall_pct <= 11;
         end
      endcase
   endtask

   initial begin
      int seg;
      int seg_end;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // All-ones sextets, then line breaks skipped at a group start.
      send_beat("/", 1'b0); send_beat("/", 1'b0); send_beat("/", 1'b0);
      send_beat("/", 1'b0);
      send_beat(CHAR_CR, 1'b0); send_beat(CHAR_LF, 1'b0);
      // Invalid first character, then an invalid third one halts decoding
      // until the end-of-text beat.
      send_beat(8'hFF, 1'b0); send_beat("z", 1'b0); send_beat(8'h00, 1'b0);
      send_beat("Q", 1'b0); send_beat("A", 1'b1);
      // Invalid second character still emits a final byte.
      send_beat("T", 1'b0); send_beat(CHAR_CR, 1'b0); send_beat("W", 1'b1);
      // Invalid fourth character.
      send_beat("T", 1'b0); send_beat("W", 1'b0); send_beat("F", 1'b0);
      send_beat("=", 1'b1);
      // End of text in the middle of a group.
      send_beat("a", 1'b0); send_beat("b", 1'b1);
      // Full group closed by end of text.
      send_beat("+", 1'b0); send_beat("9", 1'b0); send_beat("0", 1'b0);
      send_beat("w", 1'b1);
      directed_beats = beats_sent;

      for (seg = 0; seg < 8; seg++) begin
         set_mix(seg % 4);
         seg_end = directed_beats + (seg + 1) * RANDOM_BEATS / 8;
         while (beats_sent < seg_end) begin
            send_message();
         end
      end
      req_valid <= 1'b0;
      rsp_stall_pct <= 0;

      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      $display("Sent %0d character beats (%0d directed) under four gap/stall mixes;",
               beats_sent, directed_beats);
      $display("checked %0d decoded byte beats.", bytes_checked);
      if (failures == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
